@@ rtl/length_prefixed_xor_deframer_macros.svh @@
// Assertion macros for the length-prefixed XOR deframer.
// Included by the top level; no other dependencies.
`ifndef LENGTH_PREFIXED_XOR_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_XOR_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define LPXD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define LPXD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LPXD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define LPXD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/lpxd_pkg.sv @@
// Shared types and constants of the length-prefixed XOR deframer.
// No dependencies.
`default_nettype none
package lpxd_pkg;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Frame status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_END   = 3'd2;
  localparam logic [2:0] ST_BAD_CHECK = 3'd3;
  localparam logic [2:0] ST_ZERO_LEN  = 3'd4;

  // Reset value of the end marker register.
  localparam logic [7:0] END_MARKER_RESET = 8'h00;

  // One input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_last;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_id;
    logic [7:0] payload_count;
    logic [7:0] check_value;
    logic [2:0] status;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/lpxd_in_reg.sv @@
// Input register stage of the deframer: holds one received word.
// Depends on lpxd_pkg.
`default_nettype none
module lpxd_in_reg (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  lpxd_pkg::in_word_t in_word,
  input  wire              take,
  output logic             held_valid,
  output lpxd_pkg::in_word_t held_word
);
  import lpxd_pkg::*;

  logic load;

  // The register refills when empty or when its word is consumed.
  assign load     = !held_valid || take;
  assign in_stall = !load;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      held_word <= in_word;
    end
  end
endmodule
`default_nettype wire

@@ rtl/lpxd_fsm.sv @@
// Frame parser of the deframer: phase, running XOR and frame fields,
// and the result for each word. Depends on lpxd_pkg.
`default_nettype none
module lpxd_fsm (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_write,
  input  wire  [7:0]         cfg_data,
  input  wire                fire,
  input  lpxd_pkg::in_word_t word,
  output logic               res_valid,
  output lpxd_pkg::result_t  res
);
  import lpxd_pkg::*;

  typedef enum logic [5:0] {
    PH_LEN  = 6'b000001,
    PH_ID   = 6'b000010,
    PH_PAY  = 6'b000100,
    PH_CHK  = 6'b001000,
    PH_END  = 6'b010000,
    PH_SKIP = 6'b100000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] end_marker;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] held_id, held_id_next;
  logic [7:0] payload_seen, payload_seen_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] held_check, held_check_next;
  logic [7:0] b;
  logic       last;

  assign b    = word.data_byte;
  assign last = word.buffer_last;

  // Next state and result for the word in the input register.
  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    held_id_next      = held_id;
    payload_seen_next = payload_seen;
    running_xor_next  = running_xor;
    held_check_next   = held_check;
    res_valid         = 1'b0;
    res               = '0;
    case (phase)
      PH_LEN: begin
        frame_length_next = b;
        held_id_next      = 8'h00;
        payload_seen_next = 8'h00;
        running_xor_next  = b;
        held_check_next   = 8'h00;
        if (b == 8'h00) begin
          res_valid  = 1'b1;
          res.kind   = KIND_STATUS;
          res.status = ST_ZERO_LEN;
          phase_next = last ? PH_LEN : PH_SKIP;
        end else if (last) begin
          res_valid         = 1'b1;
          res.kind          = KIND_STATUS;
          res.status        = ST_SHORT;
          res.payload_count = b - 8'd1;
          phase_next        = PH_LEN;
        end else begin
          phase_next = PH_ID;
        end
      end
      PH_ID: begin
        held_id_next     = b;
        running_xor_next = running_xor ^ b;
        if (last) begin
          res_valid         = 1'b1;
          res.kind          = KIND_STATUS;
          res.status        = ST_SHORT;
          res.frame_id      = b;
          res.payload_count = frame_length - 8'd1;
          phase_next        = PH_LEN;
        end else begin
          phase_next = (frame_length == 8'd1) ? PH_CHK : PH_PAY;
        end
      end
      PH_PAY: begin
        running_xor_next  = running_xor ^ b;
        payload_seen_next = payload_seen + 8'd1;
        res_valid         = 1'b1;
        res.frame_id      = held_id;
        res.payload_count = frame_length - 8'd1;
        if (last) begin
          res.kind   = KIND_STATUS;
          res.status = ST_SHORT;
          phase_next = PH_LEN;
        end else begin
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = b;
          res.byte_index   = payload_seen;
          if (payload_seen_next == frame_length - 8'd1) begin
            phase_next = PH_CHK;
          end
        end
      end
      PH_CHK: begin
        held_check_next = b;
        if (last) begin
          res_valid         = 1'b1;
          res.kind          = KIND_STATUS;
          res.status        = ST_SHORT;
          res.frame_id      = held_id;
          res.payload_count = frame_length - 8'd1;
          phase_next        = PH_LEN;
        end else begin
          phase_next = PH_END;
        end
      end
      PH_END: begin
        res_valid         = 1'b1;
        res.kind          = KIND_STATUS;
        res.frame_id      = held_id;
        res.payload_count = frame_length - 8'd1;
        res.check_value   = held_check;
        // The end marker is checked before the checksum.
        if (b != end_marker) begin
          res.status = ST_BAD_END;
        end else if (held_check != running_xor) begin
          res.status = ST_BAD_CHECK;
        end else begin
          res.status = ST_OK;
        end
        phase_next = last ? PH_LEN : PH_SKIP;
      end
      PH_SKIP: begin
        if (last) begin
          phase_next = PH_LEN;
        end
      end
      default: begin
        phase_next = PH_LEN;
      end
    endcase
  end

  // Frame state advances only when a word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEN;
      frame_length <= 8'h00;
      held_id      <= 8'h00;
      payload_seen <= 8'h00;
      running_xor  <= 8'h00;
      held_check   <= 8'h00;
    end else if (fire) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      held_id      <= held_id_next;
      payload_seen <= payload_seen_next;
      running_xor  <= running_xor_next;
      held_check   <= held_check_next;
    end
  end

  // End marker register.
  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker <= END_MARKER_RESET;
    end else if (cfg_write) begin
      end_marker <= cfg_data;
    end
  end
endmodule
`default_nettype wire

@@ rtl/lpxd_out_reg.sv @@
// Output register of the deframer: holds one result word until taken.
// Depends on lpxd_pkg.
`default_nettype none
module lpxd_out_reg (
  input  wire               clk,
  input  wire               rst,
  input  wire               fire,
  input  wire               res_valid,
  input  lpxd_pkg::result_t res,
  output logic              ready,
  output logic              out_valid,
  input  wire               out_stall,
  output lpxd_pkg::result_t out_word
);
  import lpxd_pkg::*;

  // The register may load when empty or when its word leaves now.
  assign ready = !out_valid || !out_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= fire && res_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (ready && fire && res_valid) begin
      out_word <= res;
    end
  end
endmodule
`default_nettype wire

@@ rtl/length_prefixed_xor_deframer.sv @@
// Top level of the length-prefixed XOR deframer.
// Depends on lpxd_pkg, lpxd_in_reg, lpxd_fsm, lpxd_out_reg and the macro header.
//
//   Channel  Handshake           Payload
//   input    in_valid/in_stall   data_byte, buffer_last
//   output   out_valid/out_stall kind, payload_byte, byte_index, frame_id,
//                                payload_count, check_value, status
//   config   cfg_write           cfg_data (end marker)
//
// One byte is accepted per cycle unless the output stalls; results are registered.
// The parser computes its next state combinationally from the input register.
// Reset clears both valid flags and the frame state; end marker goes to 0.
// A stall on the output holds the output register and backs up to in_stall.
`default_nettype none
`include "length_prefixed_xor_deframer_macros.svh"
module length_prefixed_xor_deframer (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_write,
  input  wire  [7:0] cfg_data,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] data_byte,
  input  wire        buffer_last,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic [7:0] byte_index,
  output logic [7:0] frame_id,
  output logic [7:0] payload_count,
  output logic [7:0] check_value,
  output logic [2:0] status
);
  import lpxd_pkg::*;

  in_word_t in_word;
  in_word_t held_word;
  logic     held_valid;
  logic     ready;
  logic     fire;
  logic     res_valid;
  result_t  res;
  result_t  out_word;

  assign in_word.data_byte   = data_byte;
  assign in_word.buffer_last = buffer_last;

  // A held word is processed whenever the output register can load.
  assign fire = held_valid && ready;

  lpxd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .take       (fire),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  lpxd_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .word      (held_word),
    .res_valid (res_valid),
    .res       (res)
  );

  lpxd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign kind          = out_word.kind;
  assign payload_byte  = out_word.payload_byte;
  assign byte_index    = out_word.byte_index;
  assign frame_id      = out_word.frame_id;
  assign payload_count = out_word.payload_count;
  assign check_value   = out_word.check_value;
  assign status        = out_word.status;

  // Input backs up only behind a full, stalled output register.
  `LPXD_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, held_valid && out_valid && out_stall, "input stalled without output backpressure")
  // Payload words lie inside the payload.
  `LPXD_ASSERT_NOW(a_index_range, clk, rst, out_valid && kind == KIND_PAYLOAD, byte_index < payload_count, "payload index beyond payload length")
  // Payload words carry no status or check byte.
  `LPXD_ASSERT_NOW(a_payload_clean, clk, rst, out_valid && kind == KIND_PAYLOAD, status == ST_OK && check_value == 8'h00, "payload word with status fields set")
  // A processed word with a result shows up at the output next cycle.
  `LPXD_ASSERT_NEXT(a_result_shown, clk, rst, fire && res_valid, out_valid, "result lost")
endmodule
`default_nettype wire

@@ verif/length_prefixed_xor_deframer_tb.sv @@
// Self-checking testbench for the length-prefixed XOR deframer.
// Depends on lpxd_pkg and length_prefixed_xor_deframer; directed words first, then random
// buffers, checked against a behavioural predictor of the frame parser or typed-in results.
`timescale 1ns / 1ps
module length_prefixed_xor_deframer_tb;
  import lpxd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int DIRECTED_ROWS = 23;

  // How a stimulus row is checked: by the predictor, or against a typed-in result.
  typedef enum logic [1:0] {
    PREDICT,
    EXPECT_NONE,
    EXPECT_RESULT
  } row_check_t;

  // Where the frame parser stands.
  typedef enum logic [2:0] {
    AWAIT_LEN,
    AWAIT_ID,
    IN_PAYLOAD,
    AWAIT_CHECK,
    AWAIT_END,
    SKIP_REST
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    row_check_t check;
    result_t    res;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  stim_row_t  cur_row = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic [7:0] frame_id;
  logic [7:0] payload_count;
  logic [7:0] check_value;
  logic [2:0] status;

  // Words waiting to be sent and results waiting to arrive.
  stim_row_t  word_q[$];
  result_t    expected_q[$];

  // Predictor state.
  parse_phase_t parse_phase = AWAIT_LEN;
  logic [7:0]   frame_len = 8'h00;
  logic [7:0]   frame_id_held = 8'h00;
  logic [7:0]   payload_done = 8'h00;
  logic [7:0]   frame_xor = 8'h00;
  logic [7:0]   check_held = 8'h00;
  logic [7:0]   marker_model = END_MARKER_RESET;

  int          cycle_count = 0;
  int          mismatches = 0;
  int          words_queued = 0;
  int          words_accepted = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  logic [15:0] stall_pattern = 16'b1110_0100_1100_0010;

  length_prefixed_xor_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (cur_row.data),
    .buffer_last  (cur_row.last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .frame_id     (frame_id),
    .payload_count(payload_count),
    .check_value  (check_value),
    .status       (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic result_t status_word(input logic [7:0] id, input logic [7:0] count,
                                          input logic [7:0] check, input logic [2:0] st);
    result_t r;
    r = '0;
    r.kind          = KIND_STATUS;
    r.frame_id      = id;
    r.payload_count = count;
    r.check_value   = check;
    r.status        = st;
    return r;
  endfunction

  // Status word built from the frame held so far.
  function automatic result_t frame_status(input logic [2:0] st, input bit with_check);
    return status_word(frame_id_held, frame_len - 8'd1, with_check ? check_held : 8'h00, st);
  endfunction

  // Advances the parser by one received byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, input logic last,
                                      output result_t r);
    r = '0;
    case (parse_phase)
      AWAIT_LEN: begin
        frame_len     = b;
        frame_id_held = 8'h00;
        payload_done  = 8'h00;
        frame_xor     = b;
        check_held    = 8'h00;
        if (b == 8'h00) begin
          r = status_word(8'h00, 8'h00, 8'h00, ST_ZERO_LEN);
          parse_phase = last ? AWAIT_LEN : SKIP_REST;
          return 1'b1;
        end
        parse_phase = AWAIT_ID;
      end
      AWAIT_ID: begin
        frame_id_held = b;
        frame_xor ^= b;
        parse_phase = (frame_len == 8'd1) ? AWAIT_CHECK : IN_PAYLOAD;
      end
      IN_PAYLOAD: begin
        if (!last) begin
          r.kind          = KIND_PAYLOAD;
          r.payload_byte  = b;
          r.byte_index    = payload_done;
          r.frame_id      = frame_id_held;
          r.payload_count = frame_len - 8'd1;
        end
        frame_xor ^= b;
        payload_done = payload_done + 8'd1;
        if (payload_done == frame_len - 8'd1) begin
          parse_phase = AWAIT_CHECK;
        end
        if (!last) begin
          return 1'b1;
        end
      end
      AWAIT_CHECK: begin
        check_held  = b;
        parse_phase = AWAIT_END;
      end
      AWAIT_END: begin
        // The end byte is judged before the checksum.
        if (b != marker_model) begin
          r = frame_status(ST_BAD_END, 1'b1);
        end else if (check_held != frame_xor) begin
          r = frame_status(ST_BAD_CHECK, 1'b1);
        end else begin
          r = frame_status(ST_OK, 1'b1);
        end
        parse_phase = last ? AWAIT_LEN : SKIP_REST;
        return 1'b1;
      end
      default: begin
        if (last) begin
          parse_phase = AWAIT_LEN;
        end
        return 1'b0;
      end
    endcase
    // The buffer ran out before the end byte.
    if (last) begin
      r = frame_status(ST_SHORT, 1'b0);
      parse_phase = AWAIT_LEN;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic stim_row_t row_of(input logic [7:0] d, input logic l,
                                       input row_check_t c, input result_t res);
    stim_row_t r;
    r.data  = d;
    r.last  = l;
    r.check = c;
    r.res   = res;
    return r;
  endfunction

  // Directed words, with the end marker at its reset value.
  function automatic stim_row_t directed_row(input int idx);
    stim_row_t r;
    r = row_of(8'h00, 1'b0, EXPECT_NONE, NO_RESULT);
    case (idx)
      // Zero length, then trailing words up to the end of the buffer.
      0:  r = row_of(8'h00, 1'b0, EXPECT_RESULT,
                     status_word(8'h00, 8'h00, 8'h00, ST_ZERO_LEN));
      1:  r = row_of(8'hFF, 1'b0, EXPECT_NONE, NO_RESULT);
      2:  r = row_of(8'h00, 1'b1, EXPECT_NONE, NO_RESULT);
      3:  r = row_of(8'h00, 1'b1, EXPECT_RESULT,
                     status_word(8'h00, 8'h00, 8'h00, ST_ZERO_LEN));
      // A good frame with one payload byte.
      4:  r = row_of(8'h02, 1'b0, EXPECT_NONE, NO_RESULT);
      5:  r = row_of(8'hFF, 1'b0, EXPECT_NONE, NO_RESULT);
      6:  r = row_of(8'hA5, 1'b0, PREDICT, NO_RESULT);
      7:  r = row_of(8'h58, 1'b0, PREDICT, NO_RESULT);
      8:  r = row_of(8'h00, 1'b1, PREDICT, NO_RESULT);
      // Wrong end byte with no payload, then a trailing word.
      9:  r = row_of(8'h01, 1'b0, EXPECT_NONE, NO_RESULT);
      10: r = row_of(8'h00, 1'b0, EXPECT_NONE, NO_RESULT);
      11: r = row_of(8'h01, 1'b0, EXPECT_NONE, NO_RESULT);
      12: r = row_of(8'h01, 1'b0, EXPECT_RESULT,
                     status_word(8'h00, 8'h00, 8'h01, ST_BAD_END));
      13: r = row_of(8'h55, 1'b1, EXPECT_NONE, NO_RESULT);
      // Wrong checksum.
      14: r = row_of(8'h01, 1'b0, EXPECT_NONE, NO_RESULT);
      15: r = row_of(8'h80, 1'b0, EXPECT_NONE, NO_RESULT);
      16: r = row_of(8'h00, 1'b0, EXPECT_NONE, NO_RESULT);
      17: r = row_of(8'h00, 1'b1, EXPECT_RESULT,
                     status_word(8'h80, 8'h00, 8'h00, ST_BAD_CHECK));
      // Buffers cut short on the length byte and inside the payload.
      18: r = row_of(8'h05, 1'b1, EXPECT_RESULT,
                     status_word(8'h00, 8'h04, 8'h00, ST_SHORT));
      19: r = row_of(8'h03, 1'b0, EXPECT_NONE, NO_RESULT);
      20: r = row_of(8'h7E, 1'b0, EXPECT_NONE, NO_RESULT);
      21: r = row_of(8'h01, 1'b0, PREDICT, NO_RESULT);
      22: r = row_of(8'hFE, 1'b1, EXPECT_RESULT,
                     status_word(8'h7E, 8'h02, 8'h00, ST_SHORT));
      default: ;
    endcase
    return r;
  endfunction

  // Queues one receive buffer: mostly well-formed frames of small length, some with a
  // corrupted checksum or end byte, cut short or followed by trailing words, and some noise.
  task automatic queue_buffer(input int forced_len);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         len;
    int         pick;
    int         cut;
    bit         truncated;
    frame_bytes = {};
    truncated = 1'b0;
    pick = $urandom_range(0, 99);
    if (forced_len < 0 && pick < 8) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (forced_len >= 0) begin
        len = forced_len;
      end else if (pick < 13) begin
        len = 0;
      end else if (pick < 85) begin
        len = $urandom_range(1, 8);
      end else if (pick < 98) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(41, 120);
      end
      sum = len[7:0];
      frame_bytes.push_back(len[7:0]);
      if (len != 0) begin
        // Id byte and payload, then checksum and end byte.
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom_range(0, 255));
          frame_bytes.push_back(b);
          sum ^= b;
        end
        frame_bytes.push_back(($urandom_range(0, 7) == 0) ?
                              sum ^ 8'($urandom_range(1, 255)) : sum);
        frame_bytes.push_back(($urandom_range(0, 7) == 0) ?
                              marker_model ^ 8'($urandom_range(1, 255)) : marker_model);
        if ($urandom_range(0, 7) == 0) begin
          cut = $urandom_range(1, frame_bytes.size() - 1);
          while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
          truncated = 1'b1;
        end
      end
      if (!truncated && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (frame_bytes[i]) begin
      word_q.push_back(row_of(frame_bytes[i], i == frame_bytes.size() - 1, PREDICT,
                              NO_RESULT));
    end
    words_queued += frame_bytes.size();
  endtask

  // Waits until every word is sent and every result has come, then lets the pipeline drain.
  task automatic wait_idle();
    @(negedge clk);
    while (word_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_end_marker(input logic [7:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    marker_model = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Sender: offers words in bursts with random gaps, and predicts each accepted word.
  always @(posedge clk) begin : send_words
    stim_row_t next_row;
    result_t   predicted;
    bit        produced;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        produced = deframe_byte(cur_row.data, cur_row.last, predicted);
        case (cur_row.check)
          PREDICT: begin
            if (produced) begin
              expected_q.push_back(predicted);
            end
          end
          EXPECT_RESULT: expected_q.push_back(cur_row.res);
          default: ;
        endcase
        words_accepted <= words_accepted + 1;
      end
      // A stalled word stays on the port unchanged.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          next_row = word_q.pop_front();
          in_valid <= 1'b1;
          cur_row  <= next_row;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off once the run is under way, otherwise a rotating mix of
  // no stall, light random stall, a fixed bit pattern and heavy random stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && words_accepted >= HOLD_AFTER) begin
      out_stall      <= 1'b1;
      hold_left      <= HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else begin
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      case (cycle_count[10:9])
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(0, 2) == 0);
        2'd2:    out_stall <= stall_pattern[15];
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Checks every accepted result word against the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: kind %0b status %0d",
                                  kind, status));
      end else begin
        want = expected_q.pop_front();
        compare_field("kind", {7'd0, kind}, {7'd0, want.kind});
        compare_field("payload_byte", payload_byte, want.payload_byte);
        compare_field("byte_index", byte_index, want.byte_index);
        compare_field("frame_id", frame_id, want.frame_id);
        compare_field("payload_count", payload_count, want.payload_count);
        compare_field("check_value", check_value, want.check_value);
        compare_field("status", {5'd0, status}, {5'd0, want.status});
      end
    end
  end

  initial begin
    logic [7:0] marker;
    int         stop_at;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words with the end marker at reset.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      word_q.push_back(directed_row(i));
    end
    words_queued += DIRECTED_ROWS;
    wait_idle();

    // Random buffers under several end markers, each setting run in two halves
    // with the sender paused until all results are back in between.
    for (int setting = 0; setting < 5; setting++) begin
      case (setting)
        0:       marker = END_MARKER_RESET;
        1:       marker = 8'hFF;
        2:       marker = 8'h7E;
        3:       marker = 8'($urandom_range(1, 254));
        default: marker = 8'h00;
      endcase
      if (setting > 0) begin
        write_end_marker(marker);
      end
      // The longest frames appear only once each.
      if (setting == 2) begin
        queue_buffer(255);
        queue_buffer(254);
      end
      repeat (2) begin
        stop_at = words_queued + 80;
        while (words_queued < stop_at) queue_buffer(-1);
        wait_idle();
      end
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lpxd_pkg.sv
rtl/lpxd_in_reg.sv
rtl/lpxd_fsm.sv
rtl/lpxd_out_reg.sv
rtl/length_prefixed_xor_deframer.sv
verif/length_prefixed_xor_deframer_tb.sv
